### hw/rtl/bound_list_box_intersect_defines.svh
// Assertion macros for the bound list intersect block.
// No dependencies; included by the files that carry assertions.
`ifndef BOUND_LIST_BOX_INTERSECT_DEFINES_SVH
`define BOUND_LIST_BOX_INTERSECT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BLIB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BLIB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/blib_pkg.sv
// Shared types and constants for the bound list intersect block.
// No dependencies.
package blib_pkg;

    localparam int COORD_WIDTH_DEFAULT = 32;
    localparam int KIND_WIDTH          = 2;
    localparam int CFG_IDX_WIDTH       = 3;

    // bound kind codes, shared by the element and the query
    localparam logic [KIND_WIDTH-1:0] KIND_BOX  = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_SEG  = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_DIAG = 2'd2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_QUERY_KIND = 3'd0,
        REG_QUERY_C0   = 3'd1,
        REG_QUERY_C1   = 3'd2,
        REG_QUERY_C2   = 3'd3,
        REG_QUERY_C3   = 3'd4
    } cfg_reg_t;

    // which test a pairing needs
    typedef enum logic [1:0] {
        MODE_MISS = 2'd0,
        MODE_BOX  = 2'd1,
        MODE_DIAG = 2'd2
    } test_mode_t;

endpackage

### hw/rtl/bound_list_box_intersect.sv
// Top level of the bound list / query overlap test.
// Depends on blib_pkg, blib_cfg, blib_prep, blib_test and the defines header.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------
//  elements  | elem_valid, elem_ready | elem_kind, elem_c0..3, elem_last
//  result    | hit_valid, hit_ready   | list_hit
//  config    | cfg_we                 | cfg_index, cfg_data
//
//  One element per cycle while no last element waits on the result register; the
//  last element passes the input register, operand register and result register before its result shows.
//  Reset clears the pipeline valids, the running hit and the query registers.
//  A last element waits in the operand register while the result register still
//  holds an untaken result; elements behind it wait too, and the input stalls once
//  the input register is full. A non-last element in the operand register never waits.
`include "bound_list_box_intersect_defines.svh"

module bound_list_box_intersect #(
    parameter int COORD_WIDTH = blib_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [blib_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [COORD_WIDTH-1:0]              cfg_data,
    // element stream
    input  logic                                elem_valid,
    output logic                                elem_ready,
    input  logic [blib_pkg::KIND_WIDTH-1:0]     elem_kind,
    input  logic signed [COORD_WIDTH-1:0]       elem_c0,
    input  logic signed [COORD_WIDTH-1:0]       elem_c1,
    input  logic signed [COORD_WIDTH-1:0]       elem_c2,
    input  logic signed [COORD_WIDTH-1:0]       elem_c3,
    input  logic                                elem_last,
    // list result
    output logic                                hit_valid,
    input  logic                                hit_ready,
    output logic                                list_hit
);
    import blib_pkg::*;

    localparam int EW = COORD_WIDTH + 3;

    // query registers
    logic [KIND_WIDTH-1:0]         query_kind;
    logic signed [COORD_WIDTH-1:0] query_c [4];

    // input register (stage A)
    logic                          a_valid_reg, a_valid_next;
    logic [KIND_WIDTH-1:0]         a_kind_reg;
    logic signed [COORD_WIDTH-1:0] a_c_reg [4];
    logic                          a_last_reg;

    // prepared operands (feed stage B)
    test_mode_t                    prep_mode;
    logic signed [EW-1:0]          prep_p [4];
    logic signed [EW-1:0]          prep_q [4];
    logic signed [EW-1:0]          prep_uva [4];
    logic signed [EW-1:0]          prep_uvb [4];

    // operand register (stage B)
    logic                          b_valid_reg, b_valid_next;
    logic                          b_last_reg;
    test_mode_t                    b_mode_reg;
    logic signed [EW-1:0]          b_p_reg [4];
    logic signed [EW-1:0]          b_q_reg [4];
    logic signed [EW-1:0]          b_uva_reg [4];
    logic signed [EW-1:0]          b_uvb_reg [4];

    // running OR and result register
    logic                          b_hit;
    logic                          hit_now;
    logic                          hit_so_far_reg, hit_so_far_next;
    logic                          hit_valid_reg, hit_valid_next;
    logic                          list_hit_reg;

    // flow control
    logic                          elem_xfer;
    logic                          a_fire;
    logic                          b_fire;
    logic                          b_free;
    logic                          result_load;

    blib_cfg #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .query_kind (query_kind),
        .query_c    (query_c)
    );

    blib_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .elem_kind  (a_kind_reg),
        .elem_c     (a_c_reg),
        .query_kind (query_kind),
        .query_c    (query_c),
        .mode       (prep_mode),
        .p          (prep_p),
        .q          (prep_q),
        .uv_a       (prep_uva),
        .uv_b       (prep_uvb)
    );

    blib_test #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_test (
        .mode (b_mode_reg),
        .p    (b_p_reg),
        .q    (b_q_reg),
        .uv_a (b_uva_reg),
        .uv_b (b_uvb_reg),
        .hit  (b_hit)
    );

    // A last element leaves stage B only when the result register is free
    // or is being emptied in this cycle.
    always_comb
    begin
        b_fire      = b_valid_reg && (!b_last_reg || !hit_valid_reg || hit_ready);
        b_free      = !b_valid_reg || b_fire;
        a_fire      = a_valid_reg && b_free;
        elem_ready  = !a_valid_reg || a_fire;
        elem_xfer   = elem_valid && elem_ready;
        result_load = b_fire && b_last_reg;
        hit_now     = hit_so_far_reg || b_hit;

        a_valid_next = elem_xfer || (a_valid_reg && !a_fire);
        b_valid_next = a_fire || (b_valid_reg && !b_fire);

        hit_so_far_next = hit_so_far_reg;
        if (b_fire)
        begin
            hit_so_far_next = b_last_reg ? 1'b0 : hit_now;
        end

        hit_valid_next = result_load || (hit_valid_reg && !hit_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            hit_so_far_reg <= 1'b0;
            hit_valid_reg  <= 1'b0;
        end
        else
        begin
            a_valid_reg    <= a_valid_next;
            b_valid_reg    <= b_valid_next;
            hit_so_far_reg <= hit_so_far_next;
            hit_valid_reg  <= hit_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (elem_xfer)
        begin
            a_kind_reg <= elem_kind;
            a_c_reg[0] <= elem_c0;
            a_c_reg[1] <= elem_c1;
            a_c_reg[2] <= elem_c2;
            a_c_reg[3] <= elem_c3;
            a_last_reg <= elem_last;
        end
        if (a_fire)
        begin
            b_last_reg <= a_last_reg;
            b_mode_reg <= prep_mode;
            b_p_reg    <= prep_p;
            b_q_reg    <= prep_q;
            b_uva_reg  <= prep_uva;
            b_uvb_reg  <= prep_uvb;
        end
        if (result_load)
        begin
            list_hit_reg <= hit_now;
        end
    end

    assign hit_valid = hit_valid_reg;
    assign list_hit  = list_hit_reg;

    // checks on the list accumulation and the result stall
    `BLIB_ASSERT_NEXT(a_last_gives_result, clk, rst_n, result_load, hit_valid_reg,
        "last element transfer did not produce a result")
    `BLIB_ASSERT_NEXT(a_running_hit_cleared, clk, rst_n, result_load, !hit_so_far_reg,
        "running hit not cleared after last element")
    `BLIB_ASSERT_NEXT(a_miss_keeps_clear, clk, rst_n,
        b_fire && !b_last_reg && b_mode_reg == MODE_MISS && !hit_so_far_reg,
        !hit_so_far_reg, "miss pairing set the running hit")
    `BLIB_ASSERT_IMPL(a_result_not_overwritten, clk, rst_n,
        hit_valid_reg && !hit_ready && b_valid_reg && b_last_reg, !b_fire,
        "pending result overwritten by a new last element")

endmodule

### hw/rtl/blib_cfg.sv
// Query configuration registers.
// Depends on blib_pkg.
module blib_cfg #(
    parameter int COORD_WIDTH = blib_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [blib_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0]               cfg_data,
    output logic [blib_pkg::KIND_WIDTH-1:0]      query_kind,
    output logic signed [COORD_WIDTH-1:0]        query_c [4]
);
    import blib_pkg::*;

    logic [KIND_WIDTH-1:0]         kind_reg;
    logic signed [COORD_WIDTH-1:0] coord_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_BOX;
            for (int i = 0; i < 4; i++)
            begin
                coord_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUERY_KIND: kind_reg     <= cfg_data[KIND_WIDTH-1:0];
                REG_QUERY_C0:   coord_reg[0] <= cfg_data;
                REG_QUERY_C1:   coord_reg[1] <= cfg_data;
                REG_QUERY_C2:   coord_reg[2] <= cfg_data;
                REG_QUERY_C3:   coord_reg[3] <= cfg_data;
                default:        ; // unused index: ignored
            endcase
        end
    end

    assign query_kind = kind_reg;
    assign query_c    = coord_reg;

endmodule

### hw/rtl/blib_prep.sv
// Operand preparation: picks the pairing and builds the box and u/v operands.
// Depends on blib_pkg.
module blib_prep #(
    parameter int COORD_WIDTH = blib_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic [blib_pkg::KIND_WIDTH-1:0]  elem_kind,
    input  logic signed [COORD_WIDTH-1:0]    elem_c [4],
    input  logic [blib_pkg::KIND_WIDTH-1:0]  query_kind,
    input  logic signed [COORD_WIDTH-1:0]    query_c [4],
    output blib_pkg::test_mode_t             mode,
    output logic signed [COORD_WIDTH+2:0]    p [4],
    output logic signed [COORD_WIDTH+2:0]    q [4],
    output logic signed [COORD_WIDTH+2:0]    uv_a [4],
    output logic signed [COORD_WIDTH+2:0]    uv_b [4]
);
    import blib_pkg::*;

    localparam int EW = COORD_WIDTH + 3;

    function automatic logic signed [EW-1:0] ext(input logic signed [COORD_WIDTH-1:0] x);
        ext = {{3{x[COORD_WIDTH-1]}}, x};
    endfunction

    function automatic logic signed [EW-1:0] min2(input logic signed [EW-1:0] a,
                                                  input logic signed [EW-1:0] b);
        min2 = (a < b) ? a : b;
    endfunction

    function automatic logic signed [EW-1:0] max2(input logic signed [EW-1:0] a,
                                                  input logic signed [EW-1:0] b);
        max2 = (a > b) ? a : b;
    endfunction

    logic                 diag_is_query;
    logic signed [EW-1:0] dx [4];   // diagonal block: xs, ys, xe, ye
    logic signed [EW-1:0] bx [4];   // box partner: xmin, ymin, xmax, ymax
    logic signed [EW-1:0] ex [4];
    logic signed [EW-1:0] qx [4];
    logic signed [EW-1:0] sig2;     // twice sigma
    logic signed [EW-1:0] r [4];

    always_comb
    begin
        diag_is_query = (query_kind == KIND_DIAG);
        for (int i = 0; i < 4; i++)
        begin
            ex[i] = ext(elem_c[i]);
            qx[i] = ext(query_c[i]);
            dx[i] = diag_is_query ? qx[i] : ex[i];
            bx[i] = diag_is_query ? ex[i] : qx[i];
        end

        sig2 = dx[0] + dx[1] + dx[2] + dx[3];

        // reflected box, double scale
        r[0] = min2(min2(dx[0] <<< 1, dx[2] <<< 1),
                    min2(sig2 - (dx[1] <<< 1), sig2 - (dx[3] <<< 1)));
        r[2] = max2(max2(dx[0] <<< 1, dx[2] <<< 1),
                    max2(sig2 - (dx[1] <<< 1), sig2 - (dx[3] <<< 1)));
        r[1] = min2(min2(dx[1] <<< 1, dx[3] <<< 1),
                    min2(sig2 - (dx[0] <<< 1), sig2 - (dx[2] <<< 1)));
        r[3] = max2(max2(dx[1] <<< 1, dx[3] <<< 1),
                    max2(sig2 - (dx[0] <<< 1), sig2 - (dx[2] <<< 1)));

        // rotated ranges: umin, umax, vmin, vmax
        uv_a[0] = min2(dx[0] + dx[1], dx[2] + dx[3]);
        uv_a[1] = max2(dx[0] + dx[1], dx[2] + dx[3]);
        uv_a[2] = min2(dx[0] - dx[1], dx[2] - dx[3]);
        uv_a[3] = max2(dx[0] - dx[1], dx[2] - dx[3]);
        uv_b[0] = bx[0] + bx[1];
        uv_b[1] = bx[2] + bx[3];
        uv_b[2] = bx[0] - bx[3];
        uv_b[3] = bx[2] - bx[1];

        mode = MODE_MISS;
        p    = ex;
        q    = qx;
        if (query_kind == KIND_BOX)
        begin
            case (elem_kind)
                KIND_BOX:  mode = MODE_BOX;
                KIND_SEG:
                begin
                    mode = MODE_BOX;
                    p[0] = min2(ex[0], ex[2]);
                    p[2] = max2(ex[0], ex[2]);
                    p[1] = min2(ex[1], ex[3]);
                    p[3] = max2(ex[1], ex[3]);
                end
                KIND_DIAG: mode = MODE_DIAG;
                default:   mode = MODE_MISS;
            endcase
        end
        else if (diag_is_query && elem_kind == KIND_BOX)
        begin
            mode = MODE_DIAG;
        end

        if (mode == MODE_DIAG)
        begin
            p = r;
            for (int i = 0; i < 4; i++)
            begin
                q[i] = bx[i] <<< 1;
            end
        end
    end

endmodule

### hw/rtl/blib_test.sv
// Interval tests on the prepared operands; gives the hit of one element.
// Depends on blib_pkg.
module blib_test #(
    parameter int COORD_WIDTH = blib_pkg::COORD_WIDTH_DEFAULT
) (
    input  blib_pkg::test_mode_t           mode,
    input  logic signed [COORD_WIDTH+2:0]  p [4],
    input  logic signed [COORD_WIDTH+2:0]  q [4],
    input  logic signed [COORD_WIDTH+2:0]  uv_a [4],
    input  logic signed [COORD_WIDTH+2:0]  uv_b [4],
    output logic                           hit
);
    import blib_pkg::*;

    logic box_ok;
    logic uv_ok;

    always_comb
    begin
        box_ok = !(p[0] > q[2] || p[2] < q[0] || p[1] > q[3] || p[3] < q[1]);
        uv_ok  = !(uv_a[0] > uv_b[1] || uv_b[0] > uv_a[1] ||
                   uv_a[2] > uv_b[3] || uv_b[2] > uv_a[3]);
        case (mode)
            MODE_BOX:  hit = box_ok;
            MODE_DIAG: hit = box_ok && uv_ok;
            default:   hit = 1'b0;
        endcase
    end

endmodule
